### hdl/rpu_pkg.sv
// Shared types and constants for the RMSprop parameter update core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package rpu_pkg;

	// Field and arithmetic widths
	localparam int IDX_W     = 12;
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int LR_W      = 24;
	localparam int ALPHA_W   = 16;
	localparam int MEAN_W    = 32;
	localparam int MEM_DEPTH = 4096;
	localparam int ADDR_W    = 12;
	localparam int SQIN_W    = MEAN_W + FRAC_W;     // radicand of the square root
	localparam int ROOT_W    = SQIN_W / 2;
	localparam int SQACC_W   = SQIN_W + 1;          // working width of the root stages
	localparam int DEN_W     = ROOT_W + 1;
	localparam int NUM_W     = LR_W + VAL_W;
	localparam int STEP_SH   = LR_W - FRAC_W;
	localparam int STEP_W    = NUM_W - STEP_SH;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_LR    = 2'd0;
	localparam logic [1:0] REG_ALPHA = 2'd1;
	localparam logic [1:0] REG_EPS   = 2'd2;
	localparam logic [1:0] REG_GAIN  = 2'd3;

	localparam logic [LR_W-1:0]    LR_RESET    = 24'd167772;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64881;
	localparam logic [15:0]        EPS_RESET   = 16'd1;
	localparam logic [15:0]        GAIN_RESET  = 16'd0;

	typedef struct packed {
		logic [LR_W-1:0]    lr;
		logic [ALPHA_W-1:0] alpha;
		logic [15:0]        eps;
		logic [15:0]        gain;
	} cfg_t;

	// Per-element sideband that travels alongside the arithmetic
	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] param;
		logic                    gneg;
		logic [VAL_W-1:0]        gmag;
		logic                    sat;
	} side_t;

endpackage

### hdl/rmsprop_param_update_core.sv
// Top level of the RMSprop parameter update core: configuration registers,
// stall control, divider set-up and the final update. Depends on rpu_pkg
// and the rpu_mean_unit, rpu_sqrt_pipe and rpu_div_pipe modules.
`timescale 1ns / 1ps
// One parameter element is taken per clock while in_stall is low, and one
// updated element leaves per clock; the whole pipeline holds while a finished
// result waits under out_stall. A result passes the store update, the 24-stage
// square root, divider set-up, 56-stage divider and output register. After
// reset the mean store is cleared, one entry a cycle; in_stall is high during
// that time, while configuration writes are taken as usual. Several updates of
// the same element may be in flight at once: the store is read, blended and
// written back with forwarding, so each sees the mean left by the one before.
module rmsprop_param_update_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rpu_pkg::PADDR_W-1:0]      paddr,
	input  logic [rpu_pkg::PDATA_W-1:0]      pwdata,
	output logic [rpu_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	// Element input
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rpu_pkg::IDX_W-1:0]        elem_index,
	input  logic signed [rpu_pkg::VAL_W-1:0] param_value,
	input  logic signed [rpu_pkg::VAL_W-1:0] grad_value,
	input  logic                             first_use,
	// Result output
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rpu_pkg::IDX_W-1:0]        elem_index_out,
	output logic signed [rpu_pkg::VAL_W-1:0] new_param,
	output logic                             saturated
);
	import rpu_pkg::*;

	localparam logic signed [49:0] NP_MAX = 50'sh0_0000_7FFF_FFFF;
	localparam logic signed [49:0] NP_MIN = 50'sh3_FFFF_8000_0000;

	// Configuration registers
	cfg_t       cfg_q;
	logic [1:0] reg_sel;
	assign reg_sel = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lr    <= LR_RESET;
			cfg_q.alpha <= ALPHA_RESET;
			cfg_q.eps   <= EPS_RESET;
			cfg_q.gain  <= GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_LR:    cfg_q.lr    <= pwdata[LR_W-1:0];
				REG_ALPHA: cfg_q.alpha <= pwdata[ALPHA_W-1:0];
				REG_EPS:   cfg_q.eps   <= pwdata[15:0];
				REG_GAIN:  cfg_q.gain  <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_LR:    prdata = PDATA_W'(cfg_q.lr);
			REG_ALPHA: prdata = PDATA_W'(cfg_q.alpha);
			REG_EPS:   prdata = PDATA_W'(cfg_q.eps);
			REG_GAIN:  prdata = PDATA_W'(cfg_q.gain);
			default:   prdata = '0;
		endcase
	end

	// The pipeline moves as a whole unless the output beat is held
	logic adv, clearing, take;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv || clearing;
	assign take     = in_valid && !in_stall;

	// Store update
	logic              mu_v;
	side_t             mu_side;
	logic [MEAN_W-1:0] mu_mean;

	rpu_mean_unit u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (take),
		.cfg      (cfg_q),
		.idx_in   (elem_index),
		.param_in (param_value),
		.grad_in  (grad_value),
		.first_in (first_use),
		.clearing (clearing),
		.out_v    (mu_v),
		.out_side (mu_side),
		.out_mean (mu_mean)
	);

	// Root of the new mean
	logic              sq_v;
	side_t             sq_side;
	logic [ROOT_W-1:0] sq_root;

	rpu_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (mu_v),
		.in_side  (mu_side),
		.in_mean  (mu_mean),
		.out_v    (sq_v),
		.out_side (sq_side),
		.out_root (sq_root)
	);

	// Divider set-up: numerator lr*|g|, denominator root+epsilon (never zero)
	logic             v_sd;
	side_t            side_sd;
	logic [NUM_W-1:0] num_sd;
	logic [DEN_W-1:0] den_sd;
	logic [DEN_W-1:0] den_raw;
	assign den_raw = DEN_W'(sq_root) + DEN_W'(cfg_q.eps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sd <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd <= sq_side;
			num_sd  <= NUM_W'(cfg_q.lr) * NUM_W'(sq_side.gmag);
			den_sd  <= (den_raw == '0) ? DEN_W'(1) : den_raw;
		end
	end

	logic             dv_v;
	side_t            dv_side;
	logic [NUM_W-1:0] dv_quot;

	rpu_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_sd),
		.in_side  (side_sd),
		.in_num   (num_sd),
		.in_den   (den_sd),
		.out_v    (dv_v),
		.out_side (dv_side),
		.out_quot (dv_quot)
	);

	// Final update: move against the gradient and clip
	logic [STEP_W-1:0]       step;
	logic signed [49:0]      np_full;
	logic signed [VAL_W-1:0] np_clip;
	logic                    np_sat;
	always_comb begin
		step    = dv_quot[NUM_W-1:STEP_SH];
		np_full = dv_side.gneg ? (50'(dv_side.param) + $signed({2'b00, step}))
		                       : (50'(dv_side.param) - $signed({2'b00, step}));
		np_sat  = 1'b0;
		if (np_full > NP_MAX) begin
			np_clip = NP_MAX[VAL_W-1:0];
			np_sat  = 1'b1;
		end else if (np_full < NP_MIN) begin
			np_clip = NP_MIN[VAL_W-1:0];
			np_sat  = 1'b1;
		end else begin
			np_clip = np_full[VAL_W-1:0];
		end
	end

	// Output register
	logic                    out_v_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] np_q;
	logic                    sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_q <= dv_side.idx;
			np_q  <= np_clip;
			sat_q <= dv_side.sat | np_sat;
		end
	end

	assign out_valid      = out_v_q;
	assign elem_index_out = idx_q;
	assign new_param      = np_q;
	assign saturated      = sat_q;

endmodule

### hdl/rpu_mean_unit.sv
// Gradient conditioning and the read-modify-write of the squared-gradient
// mean store. Depends on rpu_pkg.
`timescale 1ns / 1ps
module rpu_mean_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             take,
	input  rpu_pkg::cfg_t                    cfg,
	input  logic [rpu_pkg::IDX_W-1:0]        idx_in,
	input  logic signed [rpu_pkg::VAL_W-1:0] param_in,
	input  logic signed [rpu_pkg::VAL_W-1:0] grad_in,
	input  logic                             first_in,
	output logic                             clearing,
	output logic                             out_v,
	output rpu_pkg::side_t                   out_side,
	output logic [rpu_pkg::MEAN_W-1:0]       out_mean
);
	import rpu_pkg::*;

	localparam logic signed [33:0] G_MAX = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] G_MIN = 34'sh3_8000_0000;

	// Store and clearing pass
	logic [MEAN_W-1:0] mean_mem_q [MEM_DEPTH];
	logic [ADDR_W:0]   clr_cnt_q;
	logic              clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (ADDR_W+1)'(MEM_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end
	assign clearing = clearing_q;

	// Pipeline registers
	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [IDX_W-1:0]        idx_s1, idx_s2;
	logic signed [VAL_W-1:0] param_s1, param_s2, grad_s1, grad_s2;
	logic                    first_s1, first_s2, first_s3, first_s4, first_s5, first_s6;
	logic [VAL_W-1:0]        wd_s2;
	side_t                   side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [SQIN_W-1:0]       sq_s4;
	logic [40:0]             plo_s5, phi_s5;
	logic [65:0]             bsq_s6;
	logic [MEAN_W-1:0]       rdata_s6, mean_s7, mean_s8;
	logic [ADDR_W-1:0]       addr_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	// Stage 1: weight decay term, gain times the parameter magnitude
	logic [VAL_W-1:0] pmag_s1;
	logic [47:0]      wd_prod_s1;
	always_comb begin
		pmag_s1    = param_s1[VAL_W-1] ? (~param_s1 + 1'b1) : param_s1;
		wd_prod_s1 = 48'(cfg.gain) * 48'(pmag_s1);
	end

	// Stage 2: add the decay term and clip the gradient
	logic signed [33:0]      grad_x, wd_x, gsum;
	logic signed [VAL_W-1:0] g_s2;
	logic                    gsat_s2;
	always_comb begin
		grad_x  = 34'(grad_s2);
		wd_x    = $signed({2'b00, wd_s2});
		gsum    = param_s2[VAL_W-1] ? (grad_x - wd_x) : (grad_x + wd_x);
		gsat_s2 = 1'b0;
		if (gsum > G_MAX) begin
			g_s2    = G_MAX[VAL_W-1:0];
			gsat_s2 = 1'b1;
		end else if (gsum < G_MIN) begin
			g_s2    = G_MIN[VAL_W-1:0];
			gsat_s2 = 1'b1;
		end else begin
			g_s2 = gsum[VAL_W-1:0];
		end
	end

	// Stage 3: square of the gradient magnitude
	logic [63:0] sq_full_s3;
	assign sq_full_s3 = 64'(side_s3.gmag) * 64'(side_s3.gmag);

	// Stage 4: (1 - alpha) times the square, in two partial products
	logic [16:0] beta;
	assign beta = 17'h10000 - {1'b0, cfg.alpha};

	// Stage 6: blend with the old mean, forwarded from the two writes still in flight
	logic [ADDR_W-1:0] addr_s6, addr_s7;
	logic [MEAN_W-1:0] old_s6;
	logic [65:0]       mix_s6;
	logic [49:0]       mean_full_s6;
	assign addr_s6 = side_s6.idx[ADDR_W-1:0];
	assign addr_s7 = side_s7.idx[ADDR_W-1:0];
	always_comb begin
		if (first_s6) begin
			old_s6 = '0;
		end else if (v_s7 && (addr_s7 == addr_s6)) begin
			old_s6 = mean_s7;
		end else if (v_s8 && (addr_s8 == addr_s6)) begin
			old_s6 = mean_s8;
		end else begin
			old_s6 = rdata_s6;
		end
		mix_s6       = 66'(48'(cfg.alpha) * 48'(old_s6)) + bsq_s6;
		mean_full_s6 = mix_s6[65:16];
	end

	// Payload registers of all stages
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= idx_in;
			param_s1 <= param_in;
			grad_s1  <= grad_in;
			first_s1 <= first_in;

			idx_s2   <= idx_s1;
			param_s2 <= param_s1;
			grad_s2  <= grad_s1;
			first_s2 <= first_s1;
			wd_s2    <= wd_prod_s1[47:16];

			side_s3.idx   <= idx_s2;
			side_s3.param <= param_s2;
			side_s3.gneg  <= g_s2[VAL_W-1];
			side_s3.gmag  <= g_s2[VAL_W-1] ? (~g_s2 + 1'b1) : g_s2;
			side_s3.sat   <= gsat_s2;
			first_s3      <= first_s2;

			side_s4  <= side_s3;
			first_s4 <= first_s3;
			sq_s4    <= sq_full_s3[63:FRAC_W];

			side_s5  <= side_s4;
			first_s5 <= first_s4;
			plo_s5   <= 41'(beta) * 41'(sq_s4[23:0]);
			phi_s5   <= 41'(beta) * 41'(sq_s4[47:24]);

			side_s6  <= side_s5;
			first_s6 <= first_s5;
			bsq_s6   <= 66'(plo_s5) + (66'(phi_s5) << 24);

			side_s7.idx   <= side_s6.idx;
			side_s7.param <= side_s6.param;
			side_s7.gneg  <= side_s6.gneg;
			side_s7.gmag  <= side_s6.gmag;
			side_s7.sat   <= side_s6.sat | (|mean_full_s6[49:MEAN_W]);
			mean_s7       <= (|mean_full_s6[49:MEAN_W]) ? '1 : mean_full_s6[MEAN_W-1:0];

			addr_s8 <= addr_s7;
			mean_s8 <= mean_s7;
		end
	end

	// Memory read for the stage 5 item, data lands in stage 6
	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s6 <= mean_mem_q[side_s5.idx[ADDR_W-1:0]];
		end
	end

	// Memory write: clearing pass, then write-back from stage 7
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [MEAN_W-1:0] mem_wd;
	always_comb begin
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q[ADDR_W-1:0];
			mem_wd = '0;
		end else begin
			mem_we = v_s7 && adv;
			mem_wa = addr_s7;
			mem_wd = mean_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mean_mem_q[mem_wa] <= mem_wd;
		end
	end

	assign out_v    = v_s7;
	assign out_side = side_s7;
	assign out_mean = mean_s7;

endmodule

### hdl/rpu_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
module rpu_sqrt_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_v,
	input  rpu_pkg::side_t               in_side,
	input  logic [rpu_pkg::MEAN_W-1:0]   in_mean,
	output logic                         out_v,
	output rpu_pkg::side_t               out_side,
	output logic [rpu_pkg::ROOT_W-1:0]   out_root
);
	import rpu_pkg::*;

	logic                v_p    [ROOT_W+1];
	side_t               side_p [ROOT_W+1];
	logic [SQACC_W-1:0]  x_p    [ROOT_W+1];
	logic [SQACC_W-1:0]  r_p    [ROOT_W+1];

	assign v_p[0]    = in_v;
	assign side_p[0] = in_side;
	assign x_p[0]    = SQACC_W'({in_mean, {FRAC_W{1'b0}}});
	assign r_p[0]    = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [SQACC_W-1:0] BIT = SQACC_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [SQACC_W-1:0] trial;
		logic               fits;
		assign trial = r_p[k] + BIT;
		assign fits  = x_p[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else if (adv) begin
				v_p[k+1] <= v_p[k];
			end
		end

		// Restoring step: subtract the trial value where it fits
		always_ff @(posedge clk) begin
			if (adv) begin
				side_p[k+1] <= side_p[k];
				if (fits) begin
					x_p[k+1] <= x_p[k] - trial;
					r_p[k+1] <= (r_p[k] >> 1) + BIT;
				end else begin
					x_p[k+1] <= x_p[k];
					r_p[k+1] <= r_p[k] >> 1;
				end
			end
		end
	end

	assign out_v    = v_p[ROOT_W];
	assign out_side = side_p[ROOT_W];
	assign out_root = r_p[ROOT_W][ROOT_W-1:0];

endmodule

### hdl/rpu_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
module rpu_div_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_v,
	input  rpu_pkg::side_t              in_side,
	input  logic [rpu_pkg::NUM_W-1:0]   in_num,
	input  logic [rpu_pkg::DEN_W-1:0]   in_den,
	output logic                        out_v,
	output rpu_pkg::side_t              out_side,
	output logic [rpu_pkg::NUM_W-1:0]   out_quot
);
	import rpu_pkg::*;

	logic              v_p    [NUM_W+1];
	side_t             side_p [NUM_W+1];
	logic [NUM_W-1:0]  nq_p   [NUM_W+1];
	logic [DEN_W-1:0]  rem_p  [NUM_W+1];
	logic [DEN_W-1:0]  den_p  [NUM_W+1];

	assign v_p[0]    = in_v;
	assign side_p[0] = in_side;
	assign nq_p[0]   = in_num;
	assign rem_p[0]  = '0;
	assign den_p[0]  = in_den;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] shifted;
		logic [DEN_W:0] diff;
		logic           fits;
		assign shifted = {rem_p[k], nq_p[k][NUM_W-1]};
		assign fits    = shifted >= {1'b0, den_p[k]};
		assign diff    = shifted - {1'b0, den_p[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else if (adv) begin
				v_p[k+1] <= v_p[k];
			end
		end

		// Bring down the next numerator bit, shift the quotient bit in
		always_ff @(posedge clk) begin
			if (adv) begin
				side_p[k+1] <= side_p[k];
				den_p[k+1]  <= den_p[k];
				nq_p[k+1]   <= {nq_p[k][NUM_W-2:0], fits};
				rem_p[k+1]  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			end
		end
	end

	assign out_v    = v_p[NUM_W];
	assign out_side = side_p[NUM_W];
	assign out_quot = nq_p[NUM_W];

endmodule
